// ===== hdl/tree_lca_binary_lifting_macros.svh =====
// assertion macros used by tlbl_core
`ifndef TREE_LCA_BINARY_LIFTING_MACROS_SVH
`define TREE_LCA_BINARY_LIFTING_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TLBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TLBL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TLBL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/tlbl_pkg.sv =====
`default_nettype none

package tlbl_pkg;

    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int DEPTH_W   = 11;
    localparam int LEVELS    = 10;
    localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JUMP_AW   = LEVEL_W + NODE_W;
    localparam int JUMP_DEPTH = LEVELS * MAX_NODES;
    localparam int LIFT_W    = ((LEVELS > DEPTH_W) ? LEVELS : DEPTH_W) + 1;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PARENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0]   ancestor;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
    } tlbl_res_t;

    function automatic tlbl_res_t make_res(
        input logic [NODE_W-1:0]   anc,
        input logic [DEPTH_W-1:0]  dep,
        input logic [STATUS_W-1:0] st
    );
        tlbl_res_t r;
        r.ancestor = anc;
        r.depth    = dep;
        r.status   = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tlbl_ram.sv =====
`default_nettype none

module tlbl_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== hdl/tlbl_core.sv =====
`default_nettype none
`include "tree_lca_binary_lifting_macros.svh"

module tlbl_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         in_mode,
    input  wire logic [tlbl_pkg::NODE_W-1:0]  in_node,
    input  wire logic [tlbl_pkg::NODE_W-1:0]  in_other,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output tlbl_pkg::tlbl_res_t               res
);

    import tlbl_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_LIFT  = 3'd4;
    localparam logic [2:0] S_PAIR  = 3'd5;
    localparam logic [2:0] S_LAST  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);
    localparam logic [NODE_W-1:0]  LAST_NODE = NODE_W'(MAX_NODES - 1);

    logic [2:0]          state_reg, state_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic                mode_reg, mode_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [NODE_W-1:0]   other_reg, other_next;
    logic [NODE_W-1:0]   x_reg, x_next;
    logic [NODE_W-1:0]   y_reg, y_next;
    logic [NODE_W-1:0]   rdn_reg, rdn_next;
    logic [DEPTH_W-1:0]  dx_reg, dx_next;
    logic [DEPTH_W-1:0]  dy_reg, dy_next;
    logic [LEVEL_W-1:0]  k_reg, k_next;
    tlbl_res_t           res_reg, res_next;

    // depth store
    logic                d_we;
    logic [NODE_W-1:0]   d_waddr;
    logic [DEPTH_W-1:0]  d_wdata;
    logic [DEPTH_W-1:0]  d_node, d_other;

    // ancestor store, row {level, node}
    logic                j_we;
    logic [JUMP_AW-1:0]  j_waddr;
    logic [NODE_W-1:0]   j_wdata;
    logic [JUMP_AW-1:0]  j_raddr_a, j_raddr_b;
    logic [NODE_W-1:0]   j_rdata_a, j_rdata_b;

    logic [LEVEL_W-1:0]  k_up, k_dn;
    logic [DEPTH_W-1:0]  add_depth;
    logic [NODE_W-1:0]   add_val;
    logic                q_bad, q_swap;
    logic [NODE_W-1:0]   q_x, q_y;
    logic [DEPTH_W-1:0]  q_dx, q_dy;
    logic [LIFT_W-1:0]   step;
    logic                lift_take, pair_take;
    logic [NODE_W-1:0]   lift_x, pair_x, pair_y;
    logic [DEPTH_W-1:0]  lift_dx, pair_dx, last_dep;

    tlbl_ram #(
        .DATA_W (DEPTH_W),
        .DEPTH  (MAX_NODES),
        .ADDR_W (NODE_W)
    ) u_depth_ram (
        .clk     (clk),
        .we      (d_we),
        .waddr   (d_waddr),
        .wdata   (d_wdata),
        .raddr_a (in_node),
        .raddr_b (in_other),
        .rdata_a (d_node),
        .rdata_b (d_other)
    );

    tlbl_ram #(
        .DATA_W (NODE_W),
        .DEPTH  (JUMP_DEPTH),
        .ADDR_W (JUMP_AW)
    ) u_jump_ram (
        .clk     (clk),
        .we      (j_we),
        .waddr   (j_waddr),
        .wdata   (j_wdata),
        .raddr_a (j_raddr_a),
        .raddr_b (j_raddr_b),
        .rdata_a (j_rdata_a),
        .rdata_b (j_rdata_b)
    );

    assign k_up = k_reg + LEVEL_W'(1);
    assign k_dn = k_reg - LEVEL_W'(1);

    assign add_depth = (other_reg == '0) ? DEPTH_W'(1) : d_other + DEPTH_W'(1);
    // the row of node 0 is never written and reads as no ancestor
    assign add_val   = (rdn_reg == '0) ? '0 : j_rdata_a;

    assign q_bad  = (node_reg == '0) || (d_node == '0) || (other_reg == '0) || (d_other == '0);
    assign q_swap = d_node < d_other;
    assign q_x    = q_swap ? other_reg : node_reg;
    assign q_y    = q_swap ? node_reg : other_reg;
    assign q_dx   = q_swap ? d_other : d_node;
    assign q_dy   = q_swap ? d_node : d_other;

    // depth of a 2^k ancestor is exactly 2^k less, so depths are tracked, not read
    assign step      = LIFT_W'(1) << k_reg;
    assign lift_take = (j_rdata_a != '0) && (LIFT_W'(dx_reg) >= LIFT_W'(dy_reg) + step);
    assign lift_x    = lift_take ? j_rdata_a : x_reg;
    assign lift_dx   = lift_take ? DEPTH_W'(LIFT_W'(dx_reg) - step) : dx_reg;

    assign pair_take = (j_rdata_a != '0) && (j_rdata_b != '0) && (j_rdata_a != j_rdata_b);
    assign pair_x    = pair_take ? j_rdata_a : x_reg;
    assign pair_y    = pair_take ? j_rdata_b : y_reg;
    assign pair_dx   = pair_take ? DEPTH_W'(LIFT_W'(dx_reg) - step) : dx_reg;

    assign last_dep  = (j_rdata_a != '0) ? dx_reg - DEPTH_W'(1) : '0;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        mode_next  = mode_reg;
        node_next  = node_reg;
        other_next = other_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rdn_next   = rdn_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        d_we       = 1'b0;
        d_waddr    = node_reg;
        d_wdata    = '0;
        j_we       = 1'b0;
        j_waddr    = {k_reg, node_reg};
        j_wdata    = '0;
        j_raddr_a  = {k_reg, x_reg};
        j_raddr_b  = {k_reg, y_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                d_we     = 1'b1;
                d_waddr  = clr_reg;
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = in_mode;
                    node_next  = in_node;
                    other_next = in_other;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!mode_reg)
                begin
                    if (node_reg == '0)
                    begin
                        res_next   = make_res(node_reg, '0, ST_UNKNOWN);
                        state_next = S_DONE;
                    end
                    else if (d_node != '0)
                    begin
                        res_next   = make_res(node_reg, '0, ST_PRESENT);
                        state_next = S_DONE;
                    end
                    else if ((other_reg != '0) && (d_other == '0))
                    begin
                        res_next   = make_res(node_reg, '0, ST_NO_PARENT);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        d_we    = 1'b1;
                        d_wdata = add_depth;
                        j_we    = 1'b1;
                        j_waddr = {LEVEL_W'(0), node_reg};
                        j_wdata = other_reg;
                        dx_next = add_depth;
                        if (LEVELS == 1)
                        begin
                            res_next   = make_res(node_reg, add_depth, ST_OK);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            j_raddr_a  = {LEVEL_W'(0), other_reg};
                            rdn_next   = other_reg;
                            k_next     = LEVEL_W'(1);
                            state_next = S_ADD;
                        end
                    end
                end
                else if (q_bad)
                begin
                    res_next   = make_res('0, '0, ST_UNKNOWN);
                    state_next = S_DONE;
                end
                else
                begin
                    x_next     = q_x;
                    y_next     = q_y;
                    dx_next    = q_dx;
                    dy_next    = q_dy;
                    k_next     = TOP_LEVEL;
                    j_raddr_a  = {TOP_LEVEL, q_x};
                    state_next = S_LIFT;
                end
            end
            S_ADD:
            begin
                j_we    = 1'b1;
                j_wdata = add_val;
                if (k_reg == TOP_LEVEL)
                begin
                    res_next   = make_res(node_reg, dx_reg, ST_OK);
                    state_next = S_DONE;
                end
                else
                begin
                    j_raddr_a = {k_reg, add_val};
                    rdn_next  = add_val;
                    k_next    = k_up;
                end
            end
            S_LIFT:
            begin
                x_next  = lift_x;
                dx_next = lift_dx;
                if (k_reg == '0)
                begin
                    if (lift_x == y_reg)
                    begin
                        res_next   = make_res(lift_x, lift_dx, ST_OK);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next     = TOP_LEVEL;
                        j_raddr_a  = {TOP_LEVEL, lift_x};
                        j_raddr_b  = {TOP_LEVEL, y_reg};
                        state_next = S_PAIR;
                    end
                end
                else
                begin
                    k_next    = k_dn;
                    j_raddr_a = {k_dn, lift_x};
                end
            end
            S_PAIR:
            begin
                x_next  = pair_x;
                y_next  = pair_y;
                dx_next = pair_dx;
                if (k_reg == '0)
                begin
                    j_raddr_a  = {LEVEL_W'(0), pair_x};
                    state_next = S_LAST;
                end
                else
                begin
                    k_next    = k_dn;
                    j_raddr_a = {k_dn, pair_x};
                    j_raddr_b = {k_dn, pair_y};
                end
            end
            S_LAST:
            begin
                res_next   = make_res(j_rdata_a, last_dep, ST_OK);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        node_reg  <= node_next;
        other_reg <= other_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        rdn_reg   <= rdn_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        res_reg   <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    `TLBL_ASSERT_NXT(a_accept_look, clk, rst_n, in_valid && in_ready, state_reg == S_LOOK, "accepted word not looked up")
    `TLBL_ASSERT_IMP(a_walk_nonzero, clk, rst_n, state_reg == S_LIFT || state_reg == S_PAIR, x_reg != '0 && y_reg != '0, "lifting walked onto node zero")
    `TLBL_ASSERT_IMP(a_lift_depth, clk, rst_n, state_reg == S_LIFT, dx_reg >= dy_reg, "lifted above the shallower node")
    `TLBL_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_reg), "pending result changed")

endmodule

`default_nettype wire

// ===== hdl/tree_lca_binary_lifting.sv =====
// lowest common ancestor by binary lifting over a parent-first loaded tree
// input channel in_valid/in_ready carries one word: mode, node, other
//   mode 0 adds node under parent other (0 = root), mode 1 queries node and other
// output channel out_valid/out_ready returns one word per input word:
//   ancestor, ancestor_depth (root = 1) and status
// add: the new node's ancestor row is built from its parent's rows,
//   one level of the ancestor row written per cycle through the jump memory
// query: one ancestor read per level and pass;
//   the second pass reads both nodes' rows in the same cycle on the two read ports
// one word is worked on at a time
// after reset all 1024 depth entries are swept to zero, one entry a cycle;
//   in_ready stays low during the sweep
// a stalled receiver holds the result in the output register; one more result
//   can finish and wait inside, after which no new word is taken
`default_nettype none

module tree_lca_binary_lifting (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           mode,
    input  wire logic [tlbl_pkg::NODE_W-1:0]    node,
    input  wire logic [tlbl_pkg::NODE_W-1:0]    other,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [tlbl_pkg::NODE_W-1:0]    ancestor,
    output logic      [tlbl_pkg::DEPTH_W-1:0]   ancestor_depth,
    output logic      [tlbl_pkg::STATUS_W-1:0]  status
);

    import tlbl_pkg::*;

    logic      res_valid, res_ready;
    tlbl_res_t res;
    logic      out_valid_reg;
    tlbl_res_t out_reg;

    tlbl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (mode),
        .in_node   (node),
        .in_other  (other),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output slot frees in the same cycle the receiver takes its word
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ancestor       = out_reg.ancestor;
    assign ancestor_depth = out_reg.depth;
    assign status         = out_reg.status;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import tlbl_pkg::*;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int   QUIET_LIMIT  = 5000;
    localparam int   END_SETTLE   = 64;
    localparam int   REPORT_LIMIT = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 mode = MODE_ADD;
    logic [NODE_W-1:0]    node = '0;
    logic [NODE_W-1:0]    other = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [NODE_W-1:0]    ancestor;
    logic [DEPTH_W-1:0]   ancestor_depth;
    logic [STATUS_W-1:0]  status;

    tree_lca_binary_lifting uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .node           (node),
        .other          (other),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ancestor       (ancestor),
        .ancestor_depth (ancestor_depth),
        .status         (status)
    );

    // tree as the block should hold it; depth 0 means absent
    int unsigned        node_depth [MAX_NODES];
    logic [NODE_W-1:0]  lift_row [LEVELS][MAX_NODES];

    tlbl_res_t          owed_answers [$];
    logic [NODE_W-1:0]  live_nodes [$];
    logic [NODE_W-1:0]  last_added = '0;
    int                 fails = 0;
    int                 quiet = 0;
    int                 send_gap_pct = 0;
    int                 recv_stall_pct = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [NODE_W-1:0] hop(int k, logic [NODE_W-1:0] n);
        return (n == '0) ? '0 : lift_row[k][n];
    endfunction

    function automatic logic [NODE_W-1:0] meeting_point(logic [NODE_W-1:0] a,
                                                       logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] x, y, ax, ay;
        x = a;
        y = b;
        if (node_depth[x] < node_depth[y])
        begin
            x = b;
            y = a;
        end
        // raise the deeper node to the level of the shallower one
        for (int k = LEVELS - 1; k >= 0; k--)
        begin
            ax = hop(k, x);
            if (ax != '0 && node_depth[ax] >= node_depth[y])
                x = ax;
        end
        if (x == y)
            return x;
        for (int k = LEVELS - 1; k >= 0; k--)
        begin
            ax = hop(k, x);
            ay = hop(k, y);
            if (ax != '0 && ay != '0 && ax != ay)
            begin
                x = ax;
                y = ay;
            end
        end
        return hop(0, x);
    endfunction

    // answer for one word, updating the tree on a good add
    function automatic tlbl_res_t tree_answer(logic m, logic [NODE_W-1:0] n,
                                              logic [NODE_W-1:0] o);
        tlbl_res_t   r;
        int unsigned d;
        r.ancestor = '0;
        r.depth    = '0;
        r.status   = ST_OK;
        if (m == MODE_ADD)
        begin
            r.ancestor = n;
            if (n == '0)
                r.status = ST_UNKNOWN;
            else if (node_depth[n] != 0)
                r.status = ST_PRESENT;
            else if (o != '0 && node_depth[o] == 0)
                r.status = ST_NO_PARENT;
            else
            begin
                d = (o == '0) ? 1 : node_depth[o] + 1;
                node_depth[n] = d;
                lift_row[0][n] = o;
                for (int k = 1; k < LEVELS; k++)
                    lift_row[k][n] = hop(k - 1, hop(k - 1, n));
                r.depth = DEPTH_W'(d);
            end
        end
        else
        begin
            if (n == '0 || o == '0 || node_depth[n] == 0 || node_depth[o] == 0)
                r.status = ST_UNKNOWN;
            else
            begin
                r.ancestor = meeting_point(n, o);
                r.depth    = DEPTH_W'(node_depth[r.ancestor]);
            end
        end
        return r;
    endfunction

    function automatic logic [NODE_W-1:0] fresh_node();
        logic [NODE_W-1:0] n;
        n = NODE_W'($urandom_range(MAX_NODES - 1, 1));
        while (node_depth[n] != 0)
            n = NODE_W'($urandom_range(MAX_NODES - 1, 1));
        return n;
    endfunction

    function automatic logic [NODE_W-1:0] any_live();
        return live_nodes[$urandom_range(live_nodes.size() - 1)];
    endfunction

    task automatic send_word(input logic m, input logic [NODE_W-1:0] n,
                             input logic [NODE_W-1:0] o);
        tlbl_res_t r;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        node     <= n;
        other    <= o;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = tree_answer(m, n, o);
        owed_answers = {owed_answers, r};
        if (m == MODE_ADD && r.status == ST_OK)
        begin
            live_nodes = {live_nodes, n};
            last_added = n;
        end
        @(negedge clk);
    endtask

    // hold the sender off until every owed answer is back
    task automatic drain_answers();
        in_valid <= 1'b0;
        while (owed_answers.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_special_cases();
        send_word(MODE_ADD, 10'd0, 10'd0);        // node 0 is never a node
        send_word(MODE_ADD, 10'd1023, 10'd0);     // root at the top of the range
        send_word(MODE_ADD, 10'd1023, 10'd0);     // added twice
        send_word(MODE_ADD, 10'd512, 10'd511);    // parent not yet added
        send_word(MODE_ADD, 10'd5, 10'd5);        // own parent
        send_word(MODE_ADD, 10'd512, 10'd1023);
        send_word(MODE_ADD, 10'd1, 10'd512);
        send_word(MODE_ADD, 10'd2, 10'd0);        // second tree
        send_word(MODE_ADD, 10'd3, 10'd2);
        send_word(MODE_ADD, 10'd4, 10'd1023);
        send_word(MODE_ADD, 10'd0, 10'd1023);
        send_word(MODE_QUERY, 10'd1, 10'd4);
        send_word(MODE_QUERY, 10'd4, 10'd1);
        send_word(MODE_QUERY, 10'd1, 10'd3);      // different trees
        send_word(MODE_QUERY, 10'd1, 10'd1);
        send_word(MODE_QUERY, 10'd512, 10'd1);    // one is the other's ancestor
        send_word(MODE_QUERY, 10'd1023, 10'd1023);
        send_word(MODE_QUERY, 10'd0, 10'd1);
        send_word(MODE_QUERY, 10'd1, 10'd0);
        send_word(MODE_QUERY, 10'd1, 10'd700);    // absent node
        send_word(MODE_QUERY, 10'd1023, 10'd3);
        send_word(MODE_QUERY, 10'd0, 10'd0);
    endtask

    // long spine so the top lifting levels get used
    task automatic test_deep_chain(input int len, input int queries);
        logic [NODE_W-1:0] spine [$];
        logic [NODE_W-1:0] n;
        for (int i = 0; i < len; i++)
        begin
            n = fresh_node();
            send_word(MODE_ADD, n, (i == 0) ? 10'd0 : spine[i - 1]);
            spine = {spine, n};
        end
        for (int i = 0; i < queries; i++)
            send_word(MODE_QUERY, spine[$urandom_range(len - 1)],
                      spine[$urandom_range(len - 1)]);
        send_word(MODE_QUERY, spine[len - 1], spine[0]);
    endtask

    task automatic test_random_forest(input int words);
        int                pick, sel;
        logic [NODE_W-1:0] n, o;
        for (int i = 0; i < words; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35 && live_nodes.size() < MAX_NODES - 1)
            begin
                n   = fresh_node();
                sel = $urandom_range(9);
                if (live_nodes.size() == 0 || sel == 0)
                    o = '0;
                else if (sel < 6)
                    o = last_added;
                else
                    o = any_live();
                send_word(MODE_ADD, n, o);
            end
            else if (pick < 85 && live_nodes.size() != 0)
            begin
                n = any_live();
                o = ($urandom_range(9) == 0) ? n : any_live();
                send_word(MODE_QUERY, n, o);
            end
            else
                send_word(1'($urandom_range(1)), NODE_W'($urandom_range(MAX_NODES - 1)),
                          NODE_W'($urandom_range(MAX_NODES - 1)));
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_answers.size() == 0)
            begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("%0t: unexpected word anc %0d dep %0d st %0d",
                             $realtime, ancestor, ancestor_depth, status);
            end
            else
            begin
                tlbl_res_t want;
                want = owed_answers.pop_front();
                if (ancestor !== want.ancestor || ancestor_depth !== want.depth ||
                    status !== want.status)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: want anc %0d dep %0d st %0d, got anc %0d dep %0d st %0d",
                                 $realtime, want.ancestor, want.depth, want.status,
                                 ancestor, ancestor_depth, status);
                end
            end
        end
    end

    // covers the depth sweep after reset and the longest receiver stall
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(11, 59);
        test_special_cases();
        drain_answers();
        test_deep_chain(600, 40);
        test_random_forest(150);
        drain_answers();

        set_idling(59, 11);
        test_random_forest(150);
        drain_answers();

        set_idling(0, 0);
        test_random_forest(150);
        drain_answers();

        repeat (END_SETTLE) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
